// File: src/rte_pkg.sv
// shared types, constants and helpers for the timestamp to epoch converter
`timescale 1ns / 1ps
package rte_pkg;

	// field widths
	localparam int unsigned YEAR_W  = 14;
	localparam int unsigned FLD_W   = 7;
	localparam int unsigned EPOCH_W = 40;
	localparam int unsigned KIND_W  = 2;
	localparam int unsigned POS_W   = 5;
	localparam int unsigned ZCNT_W  = 3;

	// queue between parser and arithmetic
	localparam int unsigned QDEPTH  = 4;
	localparam int unsigned QPTR_W  = $clog2(QDEPTH);
	localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

	// number of date-time characters
	localparam logic [POS_W-1:0] POS_END = 5'd19;

	// zone kinds
	localparam logic [KIND_W-1:0] ZK_UTC  = 2'd0;
	localparam logic [KIND_W-1:0] ZK_NUM  = 2'd1;
	localparam logic [KIND_W-1:0] ZK_NONE = 2'd2;

	// ascii codes
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_T     = 8'h54;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZU    = 8'h5A;
	localparam logic [7:0] CH_ZL    = 8'h7A;

	// calendar constants
	localparam logic [YEAR_W-1:0] EPOCH_YEAR  = 14'd1970;
	localparam logic [12:0]       LEAPS_1969  = 13'd477;
	localparam logic [12:0]       RECIP_100   = 13'd5243;
	localparam int unsigned       RECIP_SHIFT = 19;
	localparam logic [16:0]       SEC_PER_DAY = 17'd86400;

	// parser phases
	typedef enum logic [6:0] {
		PH_FIELDS     = 7'b0000001,
		PH_AFTER_SEC  = 7'b0000010,
		PH_FRAC_START = 7'b0000100,
		PH_FRAC       = 7'b0001000,
		PH_ZONE_DIG   = 7'b0010000,
		PH_ZONE_UTC   = 7'b0100000,
		PH_ZONE_NUM   = 7'b1000000
	} rte_phase_t;

	// one parsed timestamp handed from parser to arithmetic
	typedef struct packed {
		logic [YEAR_W-1:0] year;
		logic [FLD_W-1:0]  month;
		logic [FLD_W-1:0]  day;
		logic [FLD_W-1:0]  hour;
		logic [FLD_W-1:0]  minute;
		logic [FLD_W-1:0]  second;
		logic              zone_neg;
		logic [FLD_W-1:0]  zone_hour;
		logic [FLD_W-1:0]  zone_minute;
		logic [KIND_W-1:0] kind;
		logic              ok;
	} rte_rec_t;

	// decimal accumulate, truncated to the accumulator width
	function automatic logic [FLD_W-1:0] acc7(input logic [FLD_W-1:0] a, input logic [3:0] v);
		logic [FLD_W+3:0] t;
		t = (FLD_W+4)'(a) * (FLD_W+4)'(10) + (FLD_W+4)'(v);
		return t[FLD_W-1:0];
	endfunction

	function automatic logic [YEAR_W-1:0] acc14(input logic [YEAR_W-1:0] a,
		input logic [3:0] v);
		logic [YEAR_W+3:0] t;
		t = (YEAR_W+4)'(a) * (YEAR_W+4)'(10) + (YEAR_W+4)'(v);
		return t[YEAR_W-1:0];
	endfunction

	// days before the first of a month, zero for months out of range
	function automatic logic [8:0] month_start(input logic [FLD_W-1:0] m);
		logic [8:0] r;
		unique case (m)
			7'd1:    r = 9'd0;
			7'd2:    r = 9'd31;
			7'd3:    r = 9'd59;
			7'd4:    r = 9'd90;
			7'd5:    r = 9'd120;
			7'd6:    r = 9'd151;
			7'd7:    r = 9'd181;
			7'd8:    r = 9'd212;
			7'd9:    r = 9'd243;
			7'd10:   r = 9'd273;
			7'd11:   r = 9'd304;
			7'd12:   r = 9'd334;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

// File: src/rte_front.sv
// character parser: checks the timestamp form and collects its fields
`timescale 1ns / 1ps
module rte_front import rte_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,      // a character transaction completes
	input  logic [7:0] chr,
	input  logic       last,
	output logic       push,
	output rte_rec_t   rec
);

	logic [POS_W-1:0]  pos_q, pos_n;
	rte_phase_t        phase_q, phase_n;
	logic              bad_q, bad_n;
	logic [YEAR_W-1:0] year_q, year_n;
	logic [FLD_W-1:0]  month_q, month_n, day_q, day_n, hour_q, hour_n;
	logic [FLD_W-1:0]  minute_q, minute_n, second_q, second_n;
	logic              zneg_q, zneg_n;
	logic [FLD_W-1:0]  zh_q, zh_n, zm_q, zm_n;
	logic [ZCNT_W-1:0] zcnt_q, zcnt_n;

	logic       dig;
	logic [3:0] dval;
	logic       step_pos;

	assign dig  = (chr >= CH_0) && (chr <= CH_9);
	assign dval = dig ? chr[3:0] : 4'd0;

	// next parser state for the current character
	always_comb begin
		pos_n    = pos_q;
		phase_n  = phase_q;
		bad_n    = bad_q;
		year_n   = year_q;
		month_n  = month_q;
		day_n    = day_q;
		hour_n   = hour_q;
		minute_n = minute_q;
		second_n = second_q;
		zneg_n   = zneg_q;
		zh_n     = zh_q;
		zm_n     = zm_q;
		zcnt_n   = zcnt_q;
		step_pos = 1'b0;
		if (!bad_q) begin
			unique case (phase_q)
				PH_FIELDS: begin
					step_pos = 1'b1;
					unique case (pos_q)
						5'd0, 5'd1, 5'd2, 5'd3: begin
							if (dig) year_n = acc14(year_q, dval);
							else step_pos = 1'b0;
						end
						5'd5, 5'd6: begin
							if (dig) month_n = acc7(month_q, dval);
							else step_pos = 1'b0;
						end
						5'd8, 5'd9: begin
							if (dig) day_n = acc7(day_q, dval);
							else step_pos = 1'b0;
						end
						5'd11, 5'd12: begin
							if (dig) hour_n = acc7(hour_q, dval);
							else step_pos = 1'b0;
						end
						5'd14, 5'd15: begin
							if (dig) minute_n = acc7(minute_q, dval);
							else step_pos = 1'b0;
						end
						5'd17, 5'd18: begin
							if (dig) second_n = acc7(second_q, dval);
							else step_pos = 1'b0;
						end
						5'd4, 5'd7: begin
							step_pos = (chr == CH_DASH);
						end
						5'd10: begin
							step_pos = (chr == CH_T) || (chr == CH_SPACE);
						end
						5'd13, 5'd16: begin
							step_pos = (chr == CH_COLON);
						end
						default: begin
							step_pos = 1'b0;
						end
					endcase
					if (step_pos) begin
						pos_n = pos_q + 5'd1;
						if (pos_n == POS_END) phase_n = PH_AFTER_SEC;
					end else begin
						bad_n = 1'b1;
					end
				end
				PH_AFTER_SEC, PH_FRAC: begin
					if (phase_q == PH_AFTER_SEC && chr == CH_DOT) begin
						phase_n = PH_FRAC_START;
					end else if (phase_q == PH_FRAC && dig) begin
						phase_n = PH_FRAC;
					end else if (chr == CH_ZU || chr == CH_ZL) begin
						phase_n = PH_ZONE_UTC;
					end else if (chr == CH_PLUS || chr == CH_DASH) begin
						zneg_n  = (chr == CH_DASH);
						phase_n = PH_ZONE_DIG;
					end else begin
						bad_n = 1'b1;
					end
				end
				PH_FRAC_START: begin
					if (dig) phase_n = PH_FRAC;
					else bad_n = 1'b1;
				end
				PH_ZONE_DIG: begin
					if (zcnt_q == 3'd2 && chr == CH_COLON) begin
						zcnt_n = 3'd3;
					end else if (!dig || zcnt_q > 3'd4) begin
						bad_n = 1'b1;
					end else if (zcnt_q <= 3'd1) begin
						zh_n   = acc7(zh_q, dval);
						zcnt_n = zcnt_q + 3'd1;
					end else begin
						zm_n = acc7(zm_q, dval);
						if (zcnt_q == 3'd4) begin
							zcnt_n  = 3'd5;
							phase_n = PH_ZONE_NUM;
						end else begin
							zcnt_n = 3'd4;
						end
					end
				end
				default: begin
					bad_n = 1'b1;
				end
			endcase
		end
	end

	// result record built from the state after this character
	always_comb begin
		rec.year        = year_n;
		rec.month       = month_n;
		rec.day         = day_n;
		rec.hour        = hour_n;
		rec.minute      = minute_n;
		rec.second      = second_n;
		rec.zone_neg    = zneg_n;
		rec.zone_hour   = zh_n;
		rec.zone_minute = zm_n;
		rec.ok          = !bad_n && (month_n <= 7'd12) &&
			(phase_n == PH_AFTER_SEC || phase_n == PH_ZONE_UTC || phase_n == PH_ZONE_NUM);
		if (!rec.ok) rec.kind = ZK_UTC;
		else if (phase_n == PH_AFTER_SEC) rec.kind = ZK_NONE;
		else if (phase_n == PH_ZONE_NUM) rec.kind = ZK_NUM;
		else rec.kind = ZK_UTC;
	end

	assign push = take && last;

	// parser state, cleared after each final character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			phase_q  <= PH_FIELDS;
			bad_q    <= 1'b0;
			year_q   <= '0;
			month_q  <= '0;
			day_q    <= '0;
			hour_q   <= '0;
			minute_q <= '0;
			second_q <= '0;
			zneg_q   <= 1'b0;
			zh_q     <= '0;
			zm_q     <= '0;
			zcnt_q   <= '0;
		end else if (take) begin
			if (last) begin
				pos_q    <= '0;
				phase_q  <= PH_FIELDS;
				bad_q    <= 1'b0;
				year_q   <= '0;
				month_q  <= '0;
				day_q    <= '0;
				hour_q   <= '0;
				minute_q <= '0;
				second_q <= '0;
				zneg_q   <= 1'b0;
				zh_q     <= '0;
				zm_q     <= '0;
				zcnt_q   <= '0;
			end else begin
				pos_q    <= pos_n;
				phase_q  <= phase_n;
				bad_q    <= bad_n;
				year_q   <= year_n;
				month_q  <= month_n;
				day_q    <= day_n;
				hour_q   <= hour_n;
				minute_q <= minute_n;
				second_q <= second_n;
				zneg_q   <= zneg_n;
				zh_q     <= zh_n;
				zm_q     <= zm_n;
				zcnt_q   <= zcnt_n;
			end
		end
	end

endmodule

// File: src/rte_queue.sv
// short fifo of parsed timestamps between parser and arithmetic
`timescale 1ns / 1ps
module rte_queue import rte_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  rte_rec_t din,
	output logic     full,
	input  logic     pop,
	output logic     empty,
	output rte_rec_t dout
);

	rte_rec_t          mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full  = (cnt_q == QCNT_W'(QDEPTH));
	assign empty = (cnt_q == '0);
	assign dout  = mem_q[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= din;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + QPTR_W'(1);
			if (pop) rd_q <= rd_q + QPTR_W'(1);
			if (push && !pop) cnt_q <= cnt_q + QCNT_W'(1);
			else if (pop && !push) cnt_q <= cnt_q - QCNT_W'(1);
		end
	end

endmodule

// File: src/rte_back.sv
// epoch arithmetic pipeline with output register
`timescale 1ns / 1ps
module rte_back import rte_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                empty,
	input  rte_rec_t            rec,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [EPOCH_W-1:0]  epoch,
	output logic [KIND_W-1:0]   kind,
	output logic                ok
);

	typedef struct packed {
		logic              ok;
		logic [KIND_W-1:0] kind;
	} rte_ctl_t;

	logic adv;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	// stage 1: reciprocal divides by 100
	logic [YEAR_W-1:0]          yprev;
	logic [YEAR_W+12:0]         pn, py;
	rte_rec_t                   rec_s1;
	logic [7:0]                 q100n_s1, q100y_s1;

	// stage 2
	logic [12:0]                leapsn_s2;
	logic [YEAR_W-1:0]          r100;
	logic                       leap;
	logic [YEAR_W-1:0]          dy;
	logic [22:0]                yd_s2;
	logic                       gt_s2;
	logic [8:0]                 mdays_s2;
	logic [FLD_W-1:0]           day_s2;
	logic [18:0]                tod_s2, off_s2;
	logic                       zneg_s2;
	rte_ctl_t                   ctl_s2;

	// stage 3
	logic [24:0]                yterm;
	logic [24:0]                days_s3;
	logic [20:0]                tadj_s3;
	rte_ctl_t                   ctl_s3;

	// stage 4
	logic [41:0]                prod_s4;
	logic [20:0]                tadj_s4;
	rte_ctl_t                   ctl_s4;

	// stage 5 is the output register
	logic [EPOCH_W-1:0]         epoch_s5;
	rte_ctl_t                   ctl_s5;
	logic [EPOCH_W-1:0]         sum;

	assign adv = !v_s5 || out_ready;
	assign pop = adv && !empty;

	assign yprev = rec.year - YEAR_W'(1);
	assign pn    = (YEAR_W+13)'(yprev) * (YEAR_W+13)'(RECIP_100);
	assign py    = (YEAR_W+13)'(rec.year) * (YEAR_W+13)'(RECIP_100);

	// leap rule from the year remainder by 100
	assign r100 = rec_s1.year - YEAR_W'(q100y_s1) * YEAR_W'(100);
	assign leap = (rec_s1.year[1:0] == 2'd0) && ((r100 != '0) || (q100y_s1[1:0] == 2'd0));
	assign dy   = rec_s1.year - EPOCH_YEAR;

	// whole-year days
	assign yterm = gt_s2 ? (25'(yd_s2) + 25'(leapsn_s2) - 25'(LEAPS_1969)) : 25'd0;

	assign sum = prod_s4[EPOCH_W-1:0] + EPOCH_W'({{(EPOCH_W-21){tadj_s4[20]}}, tadj_s4});

	// valid bits of the stall-together pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= !empty;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// payload stages
	always_ff @(posedge clk) begin
		if (adv) begin
			rec_s1   <= rec;
			q100n_s1 <= pn[RECIP_SHIFT+7:RECIP_SHIFT];
			q100y_s1 <= py[RECIP_SHIFT+7:RECIP_SHIFT];

			leapsn_s2 <= 13'((rec_s1.year - YEAR_W'(1)) >> 2) - 13'(q100n_s1)
				+ 13'(q100n_s1 >> 2);
			yd_s2    <= 23'(dy) * 23'(365);
			gt_s2    <= rec_s1.year > EPOCH_YEAR;
			mdays_s2 <= month_start(rec_s1.month) +
				9'(leap && rec_s1.month > 7'd2 && rec_s1.month <= 7'd12);
			day_s2   <= rec_s1.day;
			tod_s2   <= 19'(rec_s1.hour) * 19'(3600) + 19'(rec_s1.minute) * 19'(60)
				+ 19'(rec_s1.second);
			off_s2   <= 19'(rec_s1.zone_hour) * 19'(3600) + 19'(rec_s1.zone_minute) * 19'(60);
			zneg_s2  <= rec_s1.zone_neg;
			ctl_s2   <= '{ok: rec_s1.ok, kind: rec_s1.kind};

			days_s3 <= yterm + 25'(mdays_s2) + 25'(day_s2) - 25'd1;
			if (ctl_s2.kind == ZK_NUM && !zneg_s2) tadj_s3 <= 21'(tod_s2) - 21'(off_s2);
			else if (ctl_s2.kind == ZK_NUM) tadj_s3 <= 21'(tod_s2) + 21'(off_s2);
			else tadj_s3 <= 21'(tod_s2);
			ctl_s3 <= ctl_s2;

			prod_s4 <= {{17{days_s3[24]}}, days_s3} * 42'(SEC_PER_DAY);
			tadj_s4 <= tadj_s3;
			ctl_s4  <= ctl_s3;

			epoch_s5 <= ctl_s4.ok ? sum : '0;
			ctl_s5   <= ctl_s4;
		end
	end

	assign out_valid = v_s5;
	assign epoch     = epoch_s5;
	assign kind      = ctl_s5.ok ? ctl_s5.kind : ZK_UTC;
	assign ok        = ctl_s5.ok;

endmodule

// File: src/rfc3339_timestamp_to_epoch.sv
// Timestamp string to UTC epoch seconds converter, top level
// Throughput: one character per cycle while the queue is not full; one result per
// cycle while m_tready is high. Each result passes the queue, four arithmetic
// stages and then the output register.
// The four-entry queue lets the parser run ahead while the output stalls.
// Reset: arst_n asynchronous, clears the parser, queue and pipeline valids.
`timescale 1ns / 1ps
module rfc3339_timestamp_to_epoch import rte_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // [7:0] char_byte
	input  logic         s_tlast,   // last_char
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [39:0]  m_tdata,   // [39:0] epoch_seconds
	output logic [2:0]   m_tuser    // [1:0] zone_kind, [2] valid_res
);

	logic     take, push, full, pop, empty;
	rte_rec_t rec_in, rec_out;
	logic [KIND_W-1:0] kind;
	logic     ok;

	assign s_tready = !full;
	assign take     = s_tvalid && s_tready;

	// character parser
	rte_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.chr    (s_tdata),
		.last   (s_tlast),
		.push   (push),
		.rec    (rec_in)
	);

	// parsed timestamp queue
	rte_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (rec_in),
		.full   (full),
		.pop    (pop),
		.empty  (empty),
		.dout   (rec_out)
	);

	// epoch arithmetic
	rte_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (empty),
		.rec       (rec_out),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.epoch     (m_tdata),
		.kind      (kind),
		.ok        (ok)
	);

	assign m_tuser = {ok, kind};

endmodule

// File: tb/tb_top.sv
// self-checking testbench for the timestamp string to epoch seconds converter
`timescale 1ns / 1ps
module tb_top;
	import rte_pkg::*;

	// cycles to wait after the last result and the run limit
	localparam int unsigned DRAIN_CYCLES = 30;
	localparam int unsigned CYCLE_LIMIT  = 200000;

	// days before the first of each month in a common year
	localparam int unsigned DAYS_BEFORE_MONTH [12] =
		'{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

	// one predicted conversion result
	typedef struct {
		logic [EPOCH_W-1:0] epoch;
		logic [KIND_W-1:0]  kind;
		logic               ok;
	} stamp_t;

	logic         clk      = 1'b0;
	logic         arst_n   = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [7:0]   s_tdata  = 8'h00;   // [7:0] char_byte
	logic         s_tlast  = 1'b0;    // last_char
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [39:0]  m_tdata;            // [39:0] epoch_seconds
	logic [2:0]   m_tuser;            // [1:0] zone_kind, [2] valid_res

	int unsigned  send_idle_pct = 0;
	int unsigned  recv_idle_pct = 0;
	int unsigned  mismatch_count = 0;
	int unsigned  cycle_count = 0;

	// expected conversions in arrival order
	stamp_t       pending_stamps [$];
	// characters of the string being sent
	logic [7:0]   text_buf [$];

	// parser state mirror
	logic [POS_W-1:0]  char_pos = '0;
	rte_phase_t        parse_state = PH_FIELDS;
	logic              bad_seen = 1'b0;
	logic [YEAR_W-1:0] year_acc = '0;
	logic [FLD_W-1:0]  month_acc = '0;
	logic [FLD_W-1:0]  day_acc = '0;
	logic [FLD_W-1:0]  hour_acc = '0;
	logic [FLD_W-1:0]  minute_acc = '0;
	logic [FLD_W-1:0]  second_acc = '0;
	logic              zone_neg = 1'b0;
	logic [FLD_W-1:0]  zone_hour_acc = '0;
	logic [FLD_W-1:0]  zone_minute_acc = '0;
	logic [ZCNT_W-1:0] zone_step = '0;

	rfc3339_timestamp_to_epoch dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		$display("mismatch on %s: got %0h expected %0h", what, got, want);
		mismatch_count++;
	endtask

	// leap days in years 1..n
	function automatic longint leaps_through(input longint n);
		return n / 4 - n / 100 + n / 400;
	endfunction

	// advance the parser mirror by one character, predict on the final one
	function automatic void track_char(input logic [7:0] c, input logic last);
		logic       dig;
		logic [3:0] v;
		logic       sep_ok;
		stamp_t     res;
		longint     yr;
		longint     days;
		longint     secs;
		longint     zoff;
		dig = (c >= CH_0) && (c <= CH_9);
		v = dig ? 4'(c - CH_0) : 4'd0;
		if (!bad_seen) begin
			case (parse_state)
				PH_FIELDS: begin
					case (char_pos)
						5'd4, 5'd7:   sep_ok = (c == CH_DASH);
						5'd10:        sep_ok = (c == CH_T) || (c == CH_SPACE);
						5'd13, 5'd16: sep_ok = (c == CH_COLON);
						default:      sep_ok = dig && (char_pos < POS_END);
					endcase
					if (!sep_ok) begin
						bad_seen = 1'b1;
					end else begin
						if (dig) begin
							if (char_pos <= 3)       year_acc = 14'(year_acc * 10 + v);
							else if (char_pos <= 6)  month_acc = 7'(month_acc * 10 + v);
							else if (char_pos <= 9)  day_acc = 7'(day_acc * 10 + v);
							else if (char_pos <= 12) hour_acc = 7'(hour_acc * 10 + v);
							else if (char_pos <= 15) minute_acc = 7'(minute_acc * 10 + v);
							else                     second_acc = 7'(second_acc * 10 + v);
						end
						char_pos = char_pos + 1'b1;
						if (char_pos == POS_END)
							parse_state = PH_AFTER_SEC;
					end
				end
				PH_AFTER_SEC, PH_FRAC: begin
					if (parse_state == PH_AFTER_SEC && c == CH_DOT) begin
						parse_state = PH_FRAC_START;
					end else if (parse_state == PH_FRAC && dig) begin
						// fraction digits are skipped
					end else if (c == CH_ZU || c == CH_ZL) begin
						parse_state = PH_ZONE_UTC;
					end else if (c == CH_PLUS || c == CH_DASH) begin
						zone_neg = (c == CH_DASH);
						parse_state = PH_ZONE_DIG;
					end else begin
						bad_seen = 1'b1;
					end
				end
				PH_FRAC_START: begin
					if (dig) parse_state = PH_FRAC;
					else bad_seen = 1'b1;
				end
				PH_ZONE_DIG: begin
					if (zone_step == 3'd2 && c == CH_COLON) begin
						zone_step = 3'd3;
					end else if (!dig || zone_step > 3'd4) begin
						bad_seen = 1'b1;
					end else if (zone_step <= 3'd1) begin
						zone_hour_acc = 7'(zone_hour_acc * 10 + v);
						zone_step = zone_step + 1'b1;
					end else begin
						zone_minute_acc = 7'(zone_minute_acc * 10 + v);
						if (zone_step == 3'd4) begin
							zone_step = 3'd5;
							parse_state = PH_ZONE_NUM;
						end else begin
							zone_step = 3'd4;
						end
					end
				end
				default: bad_seen = 1'b1;
			endcase
		end
		if (last) begin
			res.ok = !bad_seen && (month_acc <= 7'd12);
			case (parse_state)
				PH_AFTER_SEC: res.kind = ZK_NONE;
				PH_ZONE_UTC:  res.kind = ZK_UTC;
				PH_ZONE_NUM:  res.kind = ZK_NUM;
				default: begin
					res.kind = ZK_UTC;
					res.ok = 1'b0;
				end
			endcase
			secs = 0;
			if (res.ok) begin
				yr = longint'(year_acc);
				days = 0;
				// years before 1970 add no year days
				if (yr > 1970)
					days = 365 * (yr - 1970) + leaps_through(yr - 1) - leaps_through(1969);
				// month zero adds no month days
				if (month_acc >= 7'd1 && month_acc <= 7'd12) begin
					days += longint'(DAYS_BEFORE_MONTH[month_acc - 1]);
					if (month_acc > 7'd2 &&
						(((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0)))
						days += 1;
				end
				days += longint'(day_acc) - 1;
				secs = days * 86400 + longint'(hour_acc) * 3600 +
					longint'(minute_acc) * 60 + longint'(second_acc);
				zoff = longint'(zone_hour_acc) * 3600 + longint'(zone_minute_acc) * 60;
				if (res.kind == ZK_NUM)
					secs = zone_neg ? secs + zoff : secs - zoff;
			end else begin
				res.kind = ZK_UTC;
			end
			res.epoch = secs[EPOCH_W-1:0];
			pending_stamps.push_back(res);
			// back to the start of a new string
			char_pos = '0;
			parse_state = PH_FIELDS;
			bad_seen = 1'b0;
			year_acc = '0;
			month_acc = '0;
			day_acc = '0;
			hour_acc = '0;
			minute_acc = '0;
			second_acc = '0;
			zone_neg = 1'b0;
			zone_hour_acc = '0;
			zone_minute_acc = '0;
			zone_step = '0;
		end
	endfunction

	// result side: random stalls and checking of each transaction
	always @(posedge clk) begin
		stamp_t want;
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_stamps.size() == 0) begin
				report_mismatch("unexpected result", {m_tuser, m_tdata}, 64'd0);
			end else begin
				want = pending_stamps.pop_front();
				if (m_tdata !== want.epoch)
					report_mismatch("epoch_seconds", m_tdata, want.epoch);
				if (m_tuser[1:0] !== want.kind)
					report_mismatch("zone_kind", m_tuser[1:0], want.kind);
				if (m_tuser[2] !== want.ok)
					report_mismatch("valid_res", m_tuser[2], want.ok);
			end
		end
	end

	// one character transaction with random idle cycles ahead of it
	task automatic send_char(input logic [7:0] c, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		track_char(c, last);
	endtask

	task automatic send_buf();
		for (int i = 0; i < text_buf.size(); i++)
			send_char(text_buf[i], i == text_buf.size() - 1);
	endtask

	task automatic send_text(input string s);
		text_buf.delete();
		for (int i = 0; i < s.len(); i++)
			text_buf.push_back(s[i]);
		send_buf();
	endtask

	function automatic void push_pair(input int unsigned value);
		text_buf.push_back(8'(CH_0 + value / 10));
		text_buf.push_back(8'(CH_0 + value % 10));
	endfunction

	// mostly in the usual range, sometimes any two digits
	function automatic int unsigned field_value(input int unsigned lo, input int unsigned hi);
		return ($urandom_range(99) < 85) ? $urandom_range(hi, lo) : $urandom_range(99, 0);
	endfunction

	// well-formed timestamp with random content, sometimes damaged
	task automatic compose_timestamp();
		int unsigned yr;
		int unsigned zone_pick;
		int unsigned mutate;
		text_buf.delete();
		yr = $urandom_range(1) ? $urandom_range(2100, 1960) : $urandom_range(9999, 0);
		push_pair(yr / 100);
		push_pair(yr % 100);
		text_buf.push_back(CH_DASH);
		push_pair(field_value(1, 12));
		text_buf.push_back(CH_DASH);
		push_pair(field_value(1, 31));
		text_buf.push_back($urandom_range(1) ? CH_T : CH_SPACE);
		push_pair(field_value(0, 23));
		text_buf.push_back(CH_COLON);
		push_pair(field_value(0, 59));
		text_buf.push_back(CH_COLON);
		push_pair(field_value(0, 60));
		if ($urandom_range(99) < 40) begin
			text_buf.push_back(CH_DOT);
			repeat ($urandom_range(6, 1))
				text_buf.push_back(8'(CH_0 + $urandom_range(9)));
		end
		zone_pick = $urandom_range(9);
		if (zone_pick == 2) begin
			text_buf.push_back(CH_ZL);
		end else if (zone_pick >= 3 && zone_pick <= 4) begin
			text_buf.push_back(CH_ZU);
		end else if (zone_pick >= 5) begin
			text_buf.push_back($urandom_range(1) ? CH_PLUS : CH_DASH);
			push_pair(field_value(0, 14));
			if ($urandom_range(1))
				text_buf.push_back(CH_COLON);
			push_pair(field_value(0, 59));
		end
		mutate = $urandom_range(99);
		if (mutate < 10)
			text_buf[$urandom_range(text_buf.size() - 1)] = 8'($urandom_range(255));
		else if (mutate < 18)
			text_buf = text_buf[0:$urandom_range(text_buf.size() - 1)];
		else if (mutate < 24)
			text_buf.push_back(8'($urandom_range(255)));
	endtask

	// each zone form and the bare date-time
	task automatic test_zone_forms();
		send_text("1970-01-01T00:00:00Z");
		send_text("2024-02-29 12:34:56z");
		send_text("2000-03-01T00:00:00.5+05:30");
		send_text("1999-12-31T23:59:59.123456-0800");
		send_text("2038-01-19T03:14:07");
	endtask

	// field extremes, month above 12, month and day zero, years before 1970
	task automatic test_field_extremes();
		send_text("0000-00-00T00:00:00Z");
		send_text("9999-12-31T99:99:99+99:99");
		send_text("2020-13-01T00:00:00Z");
		send_text("2021-00-00T00:00:00-00:00");
		send_text("1969-07-20T20:17:40Z");
	endtask

	// mismatches, short strings, trailing characters, broken fraction and zone
	task automatic test_malformed_strings();
		send_text("2020-01-01X00:00:00Z");
		send_text("2020-01");
		send_text("2020-01-01T00:00:00ZZ");
		send_text("2020-01-01T00:00:00.Z");
		send_text("2020-01-01T00:00:00.12");
		send_text("2020-01-01T00:00:00+05:3");
		send_text("2020-01-01T00:00:00+0530x");
		text_buf = '{8'h00};
		send_buf();
		text_buf = '{8'hFF};
		send_buf();
	endtask

	// random strings until about char_target characters have gone in
	task automatic test_random_strings(input int unsigned char_target);
		int unsigned sent;
		sent = 0;
		while (sent < char_target) begin
			if ($urandom_range(99) < 10) begin
				text_buf.delete();
				repeat ($urandom_range(32, 1))
					text_buf.push_back(8'($urandom_range(255)));
			end else begin
				compose_timestamp();
			end
			sent += text_buf.size();
			send_buf();
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 18;
		recv_idle_pct = 63;
		test_zone_forms();
		test_field_extremes();
		test_malformed_strings();
		test_random_strings(245);
		send_idle_pct = 63;
		recv_idle_pct = 18;
		test_random_strings(245);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_strings(245);
		s_tvalid <= 1'b0;
		while (pending_stamps.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// File: sim.f
src/rte_pkg.sv
src/rte_front.sv
src/rte_queue.sv
src/rte_back.sv
src/rfc3339_timestamp_to_epoch.sv
tb/tb_top.sv
